// File: hdl/mbp_pkg.sv
// Package for the MIDI byte stream parser: widths, status bytes and event kind codes.
`default_nettype none

package mbp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DATA_W = 7;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned WIDE_W = 14;
  localparam int unsigned CH_W   = 5;

  // Event kinds on the result channel
  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CONTROL  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PROGRAM  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_BEND     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_SONG_POS = 4'd5;
  localparam logic [KIND_W-1:0] KIND_CLOCK    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_START    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_CONTINUE = 4'd8;
  localparam logic [KIND_W-1:0] KIND_STOP     = 4'd9;

  // Channel message classes (status with channel nibble cleared)
  localparam logic [BYTE_W-1:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [BYTE_W-1:0] ST_NOTE_ON   = 8'h90;
  localparam logic [BYTE_W-1:0] ST_CONTROL   = 8'hB0;
  localparam logic [BYTE_W-1:0] ST_PROGRAM   = 8'hC0;
  localparam logic [BYTE_W-1:0] ST_PRESSURE  = 8'hD0;
  localparam logic [BYTE_W-1:0] ST_BEND      = 8'hE0;
  localparam logic [BYTE_W-1:0] ST_CLASS_MSK = 8'hF0;

  // System common and realtime statuses
  localparam logic [BYTE_W-1:0] ST_SYSEX     = 8'hF0;
  localparam logic [BYTE_W-1:0] ST_MTC       = 8'hF1;
  localparam logic [BYTE_W-1:0] ST_SONG_POS  = 8'hF2;
  localparam logic [BYTE_W-1:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [BYTE_W-1:0] ST_CLOCK     = 8'hF8;
  localparam logic [BYTE_W-1:0] ST_START     = 8'hFA;
  localparam logic [BYTE_W-1:0] ST_CONTINUE  = 8'hFB;
  localparam logic [BYTE_W-1:0] ST_STOP      = 8'hFC;

  localparam logic [CH_W-1:0]   CH_UNSET     = 5'd16;

endpackage

`default_nettype wire

// File: hdl/mbp_if.sv
// Valid/ready channel interfaces for the MIDI byte stream parser.
`default_nettype none

interface mbp_in_if;
  import mbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbp_out_if;
  import mbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [DATA_W-1:0] key_or_number;
  logic [DATA_W-1:0] value_seven;
  logic [WIDE_W-1:0] value_fourteen;

  modport source (output valid, output event_kind, output key_or_number,
                  output value_seven, output value_fourteen, input ready);
  modport sink   (input valid, input event_kind, input key_or_number,
                  input value_seven, input value_fourteen, output ready);
endinterface

`default_nettype wire

// File: hdl/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser with running status.
`default_nettype none

// MIDI byte stream parser. Bytes enter on in_ch, one per transaction, and
// completed messages leave on out_ch as one event each. The parser keeps the
// running status, up to two data bytes and a listening channel learned from
// the first channel status in effect. Note on/off, control change, program
// change, pitch bend and song position give events once their data bytes are
// in; clock, start, continue and stop give an event at once and touch no
// state. Other channels, aftertouch, pressure, time code, song select and
// sysex data are consumed silently. Rate: one byte per clock cycle sustained
// while out_ch.ready lets events drain; a byte waits in the input register, and
// its event is loaded into the output register once that is free or draining.
// The input register is the only place a byte waits, so in_ch.ready stays high
// while the input register is empty or its byte can move on, and drops only when
// both the input and output registers are full and out_ch.ready is low.

module midi_byte_stream_parser (
  input  logic clk,
  input  logic rst_n,
  mbp_in_if.sink    in_ch,
  mbp_out_if.source out_ch
);
  import mbp_pkg::*;

  // Input stage
  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_take;
  logic              advance;

  // Parser state
  logic [BYTE_W-1:0] rs_r, rs_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [DATA_W-1:0] arg0_r, arg0_nxt;
  logic [DATA_W-1:0] arg1_r, arg1_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;

  // Event decode
  logic              ev_hit;
  logic [KIND_W-1:0] ev_kind;
  logic [DATA_W-1:0] ev_num;
  logic [DATA_W-1:0] ev_v7;
  logic [WIDE_W-1:0] ev_v14;
  logic [BYTE_W-1:0] cls;
  logic              need_one;
  logic              mine;

  // Output stage
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [DATA_W-1:0] out_num_r;
  logic [DATA_W-1:0] out_v7_r;
  logic [WIDE_W-1:0] out_v14_r;

  // Move the held byte on whenever the output register is free or draining.
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);

  always_comb begin
    rs_nxt   = rs_r;
    cnt_nxt  = cnt_r;
    arg0_nxt = arg0_r;
    arg1_nxt = arg1_r;
    ch_nxt   = ch_r;
    ev_hit   = 1'b0;
    ev_kind  = KIND_NOTE_ON;
    ev_num   = '0;
    ev_v7    = '0;
    ev_v14   = '0;
    cls      = '0;
    need_one = 1'b0;
    mine     = 1'b0;

    if (in_byte_r >= ST_CLOCK) begin
      // Realtime: report the listed ones, leave all state alone.
      unique case (in_byte_r)
        ST_CLOCK: begin
          ev_hit  = 1'b1;
          ev_kind = KIND_CLOCK;
        end
        ST_START: begin
          ev_hit  = 1'b1;
          ev_kind = KIND_START;
        end
        ST_CONTINUE: begin
          ev_hit  = 1'b1;
          ev_kind = KIND_CONTINUE;
        end
        ST_STOP: begin
          ev_hit  = 1'b1;
          ev_kind = KIND_STOP;
        end
        default: ;
      endcase
    end else begin
      // Take a new status, or collect a data byte; drop surplus data.
      if (in_byte_r[BYTE_W-1]) begin
        rs_nxt  = in_byte_r;
        cnt_nxt = 2'd0;
      end else if (cnt_r != 2'd2) begin
        if (cnt_r == 2'd0) begin
          arg0_nxt = in_byte_r[DATA_W-1:0];
        end else begin
          arg1_nxt = in_byte_r[DATA_W-1:0];
        end
        cnt_nxt = cnt_r + 2'd1;
      end

      if (rs_nxt >= ST_SYSEX) begin
        unique case (rs_nxt) inside
          ST_SYSEX: cnt_nxt = 2'd1;
          ST_SONG_POS: begin
            if (cnt_nxt == 2'd2) begin
              cnt_nxt = 2'd0;
              ev_hit  = 1'b1;
              ev_kind = KIND_SONG_POS;
              ev_v14  = {arg1_nxt, arg0_nxt};
            end
          end
          ST_MTC, ST_SONG_SEL: begin
            if (cnt_nxt != 2'd0) cnt_nxt = 2'd0;
          end
          default: cnt_nxt = 2'd0;
        endcase
      end else begin
        // Learn the channel from the first channel status in effect.
        if (ch_r == CH_UNSET) ch_nxt = {1'b0, rs_nxt[3:0]};
        mine     = ({1'b0, rs_nxt[3:0]} == ch_nxt);
        cls      = rs_nxt & ST_CLASS_MSK;
        need_one = (cls == ST_PROGRAM) || (cls == ST_PRESSURE);
        if (cnt_nxt == 2'd2 || (need_one && cnt_nxt == 2'd1)) begin
          cnt_nxt = 2'd0;
          if (mine) begin
            case (cls)
              ST_NOTE_ON: begin
                ev_hit = 1'b1;
                ev_num = arg0_nxt;
                if (arg1_nxt != '0) begin
                  ev_kind = KIND_NOTE_ON;
                  ev_v7   = arg1_nxt;
                end else begin
                  ev_kind = KIND_NOTE_OFF;
                end
              end
              ST_NOTE_OFF: begin
                ev_hit  = 1'b1;
                ev_kind = KIND_NOTE_OFF;
                ev_num  = arg0_nxt;
              end
              ST_CONTROL: begin
                ev_hit  = 1'b1;
                ev_kind = KIND_CONTROL;
                ev_num  = arg0_nxt;
                ev_v7   = arg1_nxt;
              end
              ST_BEND: begin
                ev_hit  = 1'b1;
                ev_kind = KIND_BEND;
                ev_v14  = {arg1_nxt, arg0_nxt};
              end
              ST_PROGRAM: begin
                ev_hit  = 1'b1;
                ev_kind = KIND_PROGRAM;
                ev_num  = arg0_nxt;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // Clear the output on a drained transaction; load it when an event is made.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (advance && ev_hit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rs_r        <= ST_NOTE_ON;
      cnt_r       <= 2'd0;
      ch_r        <= CH_UNSET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        rs_r  <= rs_nxt;
        cnt_r <= cnt_nxt;
        ch_r  <= ch_nxt;
      end
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_ch.rx_byte;
    if (advance) begin
      arg0_r <= arg0_nxt;
      arg1_r <= arg1_nxt;
    end
    if (advance && ev_hit) begin
      out_kind_r <= ev_kind;
      out_num_r  <= ev_num;
      out_v7_r   <= ev_v7;
      out_v14_r  <= ev_v14;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = out_kind_r;
  assign out_ch.key_or_number  = out_num_r;
  assign out_ch.value_seven    = out_v7_r;
  assign out_ch.value_fourteen = out_v14_r;

  // The data byte count never passes two.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("data byte count out of range");

  // Realtime bytes leave the parser state untouched.
  a_rt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_byte_r >= ST_CLOCK) |=> ($stable(rs_r) && $stable(cnt_r) && $stable(ch_r)))
    else $error("realtime byte changed parser state");

  // Once learned, the channel never changes.
  a_ch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_r != CH_UNSET) |=> $stable(ch_r))
    else $error("learned channel changed");

  // A new event only appears after a byte left the input register.
  a_ev_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("event appeared without a processed byte");

endmodule

`default_nettype wire
